>>> src/crpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crpt_pkg;

  // fixed widths of the datapath
  localparam int ACC_W  = 64;   // evaluation accumulator and divider numerator
  localparam int SD_W   = 31;   // sample distance register
  localparam int D21_W  = 33;   // per-axis chord difference
  localparam int MAG_W  = 33;   // magnitude of a chord difference
  localparam int SQ_W   = 68;   // squared chord length
  localparam int RT_W   = 34;   // integer square root of SQ_W bits
  localparam int REM_W  = 37;   // square root partial remainder
  localparam int T_W    = 37;   // running multiple of the sample distance
  localparam int CNT_W  = 6;    // iteration counter

  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(RT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(ACC_W - 1);

  localparam logic [SD_W-1:0] SD_RESET = SD_W'(65536);

  localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -64'sd2147483648;

  // one 3D point, index 0 = x, 1 = y, 2 = z
  typedef logic [2:0][31:0] pt_t;

  // axis index
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Z = 2'd2;

  // sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQ,
    ST_ROOT,
    ST_COUNT,
    ST_PRE,
    ST_HORN,
    ST_DIV,
    ST_FIX,
    ST_EMIT
  } state_t;

  // multiply-add steps of the per-span setup
  localparam logic [2:0] OP_N2  = 3'd0;
  localparam logic [2:0] OP_N3  = 3'd1;
  localparam logic [2:0] OP_BN  = 3'd2;
  localparam logic [2:0] OP_CN  = 3'd3;
  localparam logic [2:0] OP_CN2 = 3'd4;

  // multiply-add steps of the Horner evaluation
  localparam logic [2:0] OP_H0 = 3'd0;
  localparam logic [2:0] OP_H1 = 3'd1;
  localparam logic [2:0] OP_H2 = 3'd2;

  // saturate to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[31:0];
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> src/catmull_rom_path_tessellator.sv
// Per span of n pieces (1..MAX_PIECES): setup, a 34-step square root, a piece count
//   that stops at MAX_PIECES, then per piece three axes of three multiply-adds and a
//   64-step restoring divide through one shared divider.
// Throughput: one point at a time; in_stall stays high until its last result is loaded.
// Reset (rst_n low, synchronous): empty path window, sequencer idle, no result pending,
//   sample distance 1.0 (65536).
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_path_tessellator #(
  parameter int MAX_PIECES = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [crpt_pkg::SD_W-1:0]   cfg_sample_distance,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [31:0]          in_point_x,
  input  wire logic signed [31:0]          in_point_y,
  input  wire logic signed [31:0]          in_point_z,
  input  wire logic                        in_path_end,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [31:0]               out_seg_base_x,
  output logic signed [31:0]               out_seg_base_y,
  output logic signed [31:0]               out_seg_base_z,
  output logic signed [31:0]               out_seg_dir_x,
  output logic signed [31:0]               out_seg_dir_y,
  output logic signed [31:0]               out_seg_dir_z,
  output logic                             out_run_last,
  output logic                             out_count_clamped
);
  import crpt_pkg::*;

  localparam int NW  = $clog2(MAX_PIECES + 1);
  localparam int CW  = 3 * NW;
  localparam int DVW = CW + 1;
  localparam logic [NW-1:0] NMAX = NW'(MAX_PIECES);
  localparam logic [NW-1:0] NONE = NW'(1);

  state_t state_r, state_nxt;

  logic [SD_W-1:0] sd_r;
  pt_t             win_r [3];
  logic [1:0]      have_r;

  pt_t  a_pts_r [4];
  pt_t  b_pts_r [4];
  logic has_b_r;
  logic span_r;

  logic signed [ACC_W-1:0] a2_r  [3];
  logic signed [ACC_W-1:0] b2_r  [3];
  logic signed [ACC_W-1:0] c2_r  [3];
  logic signed [ACC_W-1:0] d_r   [3];
  logic signed [D21_W-1:0] d21_r [3];

  logic [SQ_W-1:0]  sq_r;
  logic [SQ_W-1:0]  rad_r;
  logic [RT_W-1:0]  root_r;
  logic [REM_W-1:0] rem_r;
  logic [T_W-1:0]   t_r;
  logic [NW-1:0]    q_r;
  logic [NW-1:0]    n_r;
  logic             clamp_r;

  logic [2*NW-1:0]         n2_r;
  logic [CW-1:0]           n3_r;
  logic signed [ACC_W-1:0] bn_r  [3];
  logic signed [ACC_W-1:0] cn2_r [3];
  logic signed [ACC_W-1:0] acc_r;

  logic [1:0]       comp_r;
  logic [2:0]       hop_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    pe_r;

  logic             neg_r;
  logic [ACC_W-1:0] dnum_r;
  logic [DVW-1:0]   drem_r;

  logic signed [ACC_W-1:0] s_r [3];
  logic signed [ACC_W-1:0] e_r [3];

  logic        out_valid_r;
  logic [31:0] out_bx_r, out_by_r, out_bz_r, out_dx_r, out_dy_r, out_dz_r;
  logic        out_last_r, out_clamp_r;

  // ---------------------------------------------------------------
  // handshake
  logic in_acc, slot_free, emit_go;
  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign emit_go   = (state_r == ST_EMIT) && slot_free;

  // ---------------------------------------------------------------
  // span selection at accept time from the window and the new point
  pt_t        np;
  pt_t        a_nxt [4];
  pt_t        b_nxt [4];
  logic       has_a_c, has_b_c;
  pt_t        win_nxt [3];
  logic [1:0] have_nxt;

  always_comb begin
    np = {in_point_z, in_point_y, in_point_x};
    for (int k = 0; k < 4; k++) begin
      a_nxt[k] = np;
      b_nxt[k] = np;
    end
    has_a_c = 1'b0;
    has_b_c = 1'b0;
    unique case (have_r)
      2'd0: begin
      end
      2'd1: begin
        has_b_c = in_path_end;
        b_nxt   = '{win_r[0], win_r[0], np, np};
      end
      2'd2: begin
        has_a_c = 1'b1;
        has_b_c = in_path_end;
        a_nxt   = '{win_r[0], win_r[0], win_r[1], np};
        b_nxt   = '{win_r[0], win_r[1], np, np};
      end
      2'd3: begin
        has_a_c = 1'b1;
        has_b_c = in_path_end;
        a_nxt   = '{win_r[0], win_r[1], win_r[2], np};
        b_nxt   = '{win_r[1], win_r[2], np, np};
      end
      default: begin
      end
    endcase

    // window keeps the newest three points of an open path
    win_nxt  = win_r;
    have_nxt = have_r;
    if (in_path_end) begin
      have_nxt = 2'd0;
    end else if (have_r == 2'd3) begin
      win_nxt  = '{win_r[1], win_r[2], np};
    end else begin
      win_nxt[have_r] = np;
      have_nxt        = have_r + 2'd1;
    end
  end

  // ---------------------------------------------------------------
  // span coefficients, doubled: a2, b2, c2 and base d
  logic signed [ACC_W-1:0] ld_p [4][3];
  logic signed [ACC_W-1:0] ld_d21 [3];
  logic signed [ACC_W-1:0] ld_d20 [3];
  logic signed [ACC_W-1:0] ld_a2  [3];
  logic signed [ACC_W-1:0] ld_b2  [3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        ld_p[k][c] = span_r ? ACC_W'($signed(b_pts_r[k][c])) : ACC_W'($signed(a_pts_r[k][c]));
      end
    end
    for (int c = 0; c < 3; c++) begin
      ld_d21[c] = ld_p[2][c] - ld_p[1][c];
      ld_d20[c] = ld_p[2][c] - ld_p[0][c];
      ld_a2[c]  = (ld_p[3][c] - ld_p[1][c]) + ld_d20[c] - (ld_d21[c] <<< 2);
      ld_b2[c]  = (ld_d21[c] <<< 1) - ld_d20[c] - ld_a2[c];
    end
  end

  // ---------------------------------------------------------------
  // squared chord: one axis a cycle
  logic signed [D21_W:0]  sq_s;
  logic signed [D21_W:0]  sq_abs;
  logic [MAG_W-1:0]       sq_m;
  logic [2*MAG_W-1:0]     sqv;
  logic [SQ_W-1:0]        sq_sum;

  assign sq_s   = {d21_r[comp_r][D21_W-1], d21_r[comp_r]};
  assign sq_abs = sq_s[D21_W] ? -sq_s : sq_s;
  assign sq_m   = sq_abs[MAG_W-1:0];
  assign sqv    = sq_m * sq_m;
  assign sq_sum = sq_r + SQ_W'(sqv);

  // square root step, two radicand bits per cycle
  logic [REM_W-1:0] rt_shift, rt_trial;
  logic             rt_ge;
  assign rt_shift = {rem_r[REM_W-3:0], rad_r[SQ_W-1:SQ_W-2]};
  assign rt_trial = {1'b0, root_r, 2'b01};
  assign rt_ge    = (rt_shift >= rt_trial);

  // piece count step
  logic cnt_done;
  assign cnt_done = (q_r == NMAX) || (t_r > T_W'(root_r));

  // ---------------------------------------------------------------
  // shared multiply-add unit: mul_a * mul_b + mul_c
  logic signed [ACC_W-1:0]  mul_a, mul_c, mul_res;
  logic [NW-1:0]            mul_b;
  logic signed [ACC_W+NW:0] prod;

  assign prod    = mul_a * $signed({1'b0, mul_b});
  assign mul_res = prod[ACC_W-1:0] + mul_c;

  // ---------------------------------------------------------------
  // shared divider step: remainder against 2 * n^3
  logic [DVW:0] dv_shift, dv_div, dv_diff;
  logic         dv_ge;
  assign dv_shift = {drem_r, dnum_r[ACC_W-1]};
  assign dv_div   = {1'b0, n3_r, 1'b0};
  assign dv_ge    = (dv_shift >= dv_div);
  assign dv_diff  = dv_shift - dv_div;

  // floor correction of the signed quotient
  logic signed [ACC_W-1:0] fx_q, fx_rnd, fx_res;
  assign fx_q   = $signed(dnum_r);
  assign fx_rnd = $signed({{(ACC_W-1){1'b0}}, (drem_r != '0)});
  assign fx_res = neg_r ? -(fx_q + fx_rnd) : fx_q;

  logic [ACC_W-1:0] num_abs;
  assign num_abs = mul_res[ACC_W-1] ? ACC_W'(-mul_res) : ACC_W'(mul_res);

  // ---------------------------------------------------------------
  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && (has_a_c || has_b_c)) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_SQ;
      ST_SQ:    if (comp_r == AX_Z) state_nxt = ST_ROOT;
      ST_ROOT:  if (cnt_r == ROOT_LAST) state_nxt = ST_COUNT;
      ST_COUNT: if (cnt_done) state_nxt = ST_PRE;
      ST_PRE:   if (hop_r == OP_CN2 && comp_r == AX_Z) state_nxt = ST_HORN;
      ST_HORN:  if (hop_r == OP_H2) state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == DIV_LAST) state_nxt = ST_FIX;
      ST_FIX:   state_nxt = (comp_r == AX_Z) ? ST_EMIT : ST_HORN;
      ST_EMIT: begin
        if (slot_free) begin
          if (pe_r != n_r) begin
            state_nxt = ST_HORN;
          end else if (!span_r && has_b_r) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // multiply-add operand selection
  always_comb begin
    mul_a = '0;
    mul_b = n_r;
    mul_c = '0;
    unique case (state_r)
      ST_PRE: begin
        unique case (hop_r)
          OP_N2:  mul_a = $signed({{(ACC_W-NW){1'b0}}, n_r});
          OP_N3:  mul_a = $signed({{(ACC_W-2*NW){1'b0}}, n2_r});
          OP_BN:  mul_a = b2_r[comp_r];
          OP_CN:  mul_a = c2_r[comp_r];
          OP_CN2: mul_a = acc_r;
          default: mul_a = '0;
        endcase
      end
      ST_HORN: begin
        mul_b = pe_r;
        unique case (hop_r)
          OP_H0: begin
            mul_a = a2_r[comp_r];
            mul_c = bn_r[comp_r];
          end
          OP_H1: begin
            mul_a = acc_r;
            mul_c = cn2_r[comp_r];
          end
          OP_H2: begin
            mul_a = acc_r;
            mul_c = $signed({{(ACC_W-CW){1'b0}}, n3_r});
          end
          default: mul_a = '0;
        endcase
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------
  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_r      <= 2'd0;
      out_valid_r <= 1'b0;
      sd_r        <= SD_RESET;
    end else begin
      state_r <= state_nxt;
      if (in_acc) have_r <= have_nxt;
      if (cfg_valid && cfg_ready) sd_r <= cfg_sample_distance;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          win_r   <= win_nxt;
          a_pts_r <= a_nxt;
          b_pts_r <= b_nxt;
          has_b_r <= has_b_c;
          span_r  <= !has_a_c;
        end
      end
      ST_LOAD: begin
        for (int c = 0; c < 3; c++) begin
          a2_r[c]  <= ld_a2[c];
          b2_r[c]  <= ld_b2[c];
          c2_r[c]  <= ld_d20[c];
          d_r[c]   <= ld_p[1][c];
          d21_r[c] <= ld_d21[c][D21_W-1:0];
        end
        sq_r   <= '0;
        comp_r <= AX_X;
      end
      ST_SQ: begin
        sq_r   <= sq_sum;
        comp_r <= comp_r + 2'd1;
        if (comp_r == AX_Z) begin
          rad_r  <= sq_sum;
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= '0;
        end
      end
      ST_ROOT: begin
        rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
        rem_r  <= rt_ge ? (rt_shift - rt_trial) : rt_shift;
        root_r <= {root_r[RT_W-2:0], rt_ge};
        cnt_r  <= cnt_r + CNT_W'(1);
        if (cnt_r == ROOT_LAST) begin
          q_r <= '0;
          t_r <= T_W'(sd_r);
        end
      end
      ST_COUNT: begin
        if (cnt_done) begin
          n_r     <= (q_r == NMAX) ? NMAX : (q_r + NONE);
          clamp_r <= (q_r == NMAX);
          hop_r   <= OP_N2;
          comp_r  <= AX_X;
        end else begin
          q_r <= q_r + NONE;
          t_r <= t_r + T_W'(sd_r);
        end
      end
      ST_PRE: begin
        unique case (hop_r)
          OP_N2: begin
            n2_r  <= mul_res[2*NW-1:0];
            hop_r <= OP_N3;
          end
          OP_N3: begin
            n3_r  <= mul_res[CW-1:0];
            hop_r <= OP_BN;
          end
          OP_BN: begin
            bn_r[comp_r] <= mul_res;
            hop_r        <= OP_CN;
          end
          OP_CN: begin
            acc_r <= mul_res;
            hop_r <= OP_CN2;
          end
          OP_CN2: begin
            cn2_r[comp_r] <= mul_res;
            if (comp_r == AX_Z) begin
              comp_r <= AX_X;
              hop_r  <= OP_H0;
              pe_r   <= NONE;
              s_r    <= d_r;
            end else begin
              comp_r <= comp_r + 2'd1;
              hop_r  <= OP_BN;
            end
          end
          default: hop_r <= OP_N2;
        endcase
      end
      ST_HORN: begin
        acc_r <= mul_res;
        unique case (hop_r)
          OP_H0: hop_r <= OP_H1;
          OP_H1: hop_r <= OP_H2;
          OP_H2: begin
            neg_r  <= mul_res[ACC_W-1];
            dnum_r <= num_abs;
            drem_r <= '0;
            cnt_r  <= '0;
          end
          default: hop_r <= OP_H0;
        endcase
      end
      ST_DIV: begin
        drem_r <= dv_ge ? dv_diff[DVW-1:0] : dv_shift[DVW-1:0];
        dnum_r <= {dnum_r[ACC_W-2:0], dv_ge};
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      ST_FIX: begin
        e_r[comp_r] <= d_r[comp_r] + fx_res;
        hop_r       <= OP_H0;
        comp_r      <= (comp_r == AX_Z) ? AX_X : (comp_r + 2'd1);
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_bx_r    <= sat32(s_r[0]);
          out_by_r    <= sat32(s_r[1]);
          out_bz_r    <= sat32(s_r[2]);
          out_dx_r    <= sat32(e_r[0] - s_r[0]);
          out_dy_r    <= sat32(e_r[1] - s_r[1]);
          out_dz_r    <= sat32(e_r[2] - s_r[2]);
          out_last_r  <= (pe_r == n_r) && (span_r || !has_b_r);
          out_clamp_r <= clamp_r;
          s_r         <= e_r;
          pe_r        <= pe_r + NONE;
          comp_r      <= AX_X;
          hop_r       <= OP_H0;
          if (pe_r == n_r) span_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------
  // result port
  assign out_valid         = out_valid_r;
  assign out_seg_base_x    = out_bx_r;
  assign out_seg_base_y    = out_by_r;
  assign out_seg_base_z    = out_bz_r;
  assign out_seg_dir_x     = out_dx_r;
  assign out_seg_dir_y     = out_dy_r;
  assign out_seg_dir_z     = out_dz_r;
  assign out_run_last      = out_last_r;
  assign out_count_clamped = out_clamp_r;

  // ---------------------------------------------------------------
  // checks
  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HORN) |-> (n_r != '0 && n_r <= NMAX))
    else $error("piece count out of range during evaluation");

  a_pe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (pe_r != '0 && pe_r <= n_r))
    else $error("piece index beyond span piece count");

  a_clamp_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRE && clamp_r) |-> (n_r == NMAX))
    else $error("clamped span without maximum piece count");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (n3_r != '0))
    else $error("divider started with zero divisor");

  a_next_piece: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && pe_r != n_r) |=> (state_r == ST_HORN && out_valid_r && !out_last_r))
    else $error("piece loaded without continuing the span");

endmodule

`default_nettype wire
